// ----- hw/rtl/cc_pkg.sv -----
package cc_pkg;

	localparam int MAX_VERTICES_DEF = 65536;
	localparam int COUNT_BITS_DEF   = 32;
	localparam int FRAC_BITS_DEF    = 16;

	localparam int VTX_BITS   = 16;
	localparam int LABEL_BITS = 16;
	localparam int OUT_BITS   = 48;
	localparam int VOL_BITS   = 32;
	localparam int STAT_BITS  = 2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	typedef logic [STAT_BITS-1:0] cc_status_t;
	localparam cc_status_t CC_OK       = 2'd0;
	localparam cc_status_t CC_NO_CUT   = 2'd1;
	localparam cc_status_t CC_ZERO_DEN = 2'd2;
	localparam cc_status_t CC_SAT      = 2'd3;

	typedef enum logic [1:0] {
		S_RUN,
		S_START,
		S_DIV,
		S_HOLD
	} cc_state_t;

	// controller to datapath
	typedef struct packed {
		logic label_we;
		logic edge_rd;
		logic count_en;
		logic div_start;
		logic out_load;
	} cc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} cc_stat_t;

endpackage

// ----- hw/rtl/community_conductance.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------------
// in       | in_valid / in_ready   | opcode, vertex, neighbor, label, last
// out      | out_valid / out_ready | conductance, status, inside_volume,
//          |                       | outside_volume, cut_edges
// cfg      | cfg_we                | cfg_wdata (community)
//
// label loads and edges that are not last are taken back to back;
// the two labels of an edge come from the table's two read ports in the next cycle.
// a last edge's result is loaded into the output register once the restoring divider is done,
// and the next transaction can be taken from then on: the divider yields one quotient
// bit per cycle, and in_ready stays low meanwhile.
// the result waits in the output register; a further last edge stalls if it is unread.
// reset clears the counters and community; the label table is not cleared.
module community_conductance #(
	parameter int MAX_VERTICES = cc_pkg::MAX_VERTICES_DEF,
	parameter int COUNT_BITS   = cc_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS    = cc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cc_pkg::LABEL_BITS-1:0]  cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic [cc_pkg::VTX_BITS-1:0]    vertex,
	input  logic [cc_pkg::VTX_BITS-1:0]    neighbor,
	input  logic [cc_pkg::LABEL_BITS-1:0]  label,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cc_pkg::OUT_BITS-1:0]    conductance,
	output logic [cc_pkg::STAT_BITS-1:0]   status,
	output logic [cc_pkg::VOL_BITS-1:0]    inside_volume,
	output logic [cc_pkg::VOL_BITS-1:0]    outside_volume,
	output logic [cc_pkg::VOL_BITS-1:0]    cut_edges
);

	import cc_pkg::*;

	cc_cmd_t  cmd;
	cc_stat_t stat;

	cc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	cc_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COUNT_BITS   (COUNT_BITS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.vertex         (vertex),
		.neighbor       (neighbor),
		.label          (label),
		.conductance    (conductance),
		.status         (status),
		.inside_volume  (inside_volume),
		.outside_volume (outside_volume),
		.cut_edges      (cut_edges)
	);

endmodule

// ----- hw/rtl/cc_ram.sv -----
module cc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_a,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- hw/rtl/cc_divider.sv -----
module cc_divider #(
	parameter int COUNT_BITS = cc_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = cc_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [COUNT_BITS-1:0]           num,
	input  logic [COUNT_BITS-1:0]           den,
	output logic                            done,
	output logic [COUNT_BITS+FRAC_BITS-1:0] quotient
);

	localparam int NW     = COUNT_BITS + FRAC_BITS;
	localparam int STEP_W = $clog2(NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NW-1:0]     work_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;

	logic [COUNT_BITS:0]   rem_sh;
	logic                  ge;
	logic [COUNT_BITS:0]   rem_diff;

	// restoring division, one quotient bit per cycle; quotient bits shift in behind the dividend
	always_comb begin
		rem_sh   = {rem_q, work_q[NW-1]};
		ge       = rem_sh >= {1'b0, den_q};
		rem_diff = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NW);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= {num, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= {work_q[NW-2:0], ge};
			rem_q  <= ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

// ----- hw/rtl/cc_datapath.sv -----
module cc_datapath #(
	parameter int MAX_VERTICES = cc_pkg::MAX_VERTICES_DEF,
	parameter int COUNT_BITS   = cc_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS    = cc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cc_pkg::cc_cmd_t                cmd,
	output cc_pkg::cc_stat_t               stat,
	input  logic                           cfg_we,
	input  logic [cc_pkg::LABEL_BITS-1:0]  cfg_wdata,
	input  logic [cc_pkg::VTX_BITS-1:0]    vertex,
	input  logic [cc_pkg::VTX_BITS-1:0]    neighbor,
	input  logic [cc_pkg::LABEL_BITS-1:0]  label,
	output logic [cc_pkg::OUT_BITS-1:0]    conductance,
	output logic [cc_pkg::STAT_BITS-1:0]   status,
	output logic [cc_pkg::VOL_BITS-1:0]    inside_volume,
	output logic [cc_pkg::VOL_BITS-1:0]    outside_volume,
	output logic [cc_pkg::VOL_BITS-1:0]    cut_edges
);

	import cc_pkg::*;

	localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW     = COUNT_BITS + FRAC_BITS;

	logic [LABEL_BITS-1:0] community_q;
	logic [COUNT_BITS-1:0] inside_q;
	logic [COUNT_BITS-1:0] outside_q;
	logic [COUNT_BITS-1:0] cut_q;
	logic                  vtx_ok_s1;
	logic                  nbr_ok_s1;

	logic [OUT_BITS-1:0]   conductance_q;
	cc_status_t            status_q;
	logic [VOL_BITS-1:0]   inside_vol_q;
	logic [VOL_BITS-1:0]   outside_vol_q;
	logic [VOL_BITS-1:0]   cut_edges_q;

	logic [ADDR_W+VTX_BITS-1:0] vtx_ext;
	logic [ADDR_W+VTX_BITS-1:0] nbr_ext;
	logic                       vtx_in_range;
	logic                       nbr_in_range;
	logic [LABEL_BITS-1:0]      rd_vtx;
	logic [LABEL_BITS-1:0]      rd_nbr;
	logic [LABEL_BITS-1:0]      lab_vtx;
	logic [LABEL_BITS-1:0]      lab_nbr;
	logic                       is_inside;
	logic                       is_cut;
	logic [COUNT_BITS-1:0]      den;
	logic                       div_done;
	logic [NW-1:0]              quotient;
	logic [NW+OUT_BITS-1:0]     quo_ext;
	logic                       quo_sat;
	logic [COUNT_BITS+VOL_BITS-1:0] in_ext;
	logic [COUNT_BITS+VOL_BITS-1:0] out_ext;
	logic [COUNT_BITS+VOL_BITS-1:0] cut_ext;

	assign vtx_ext      = {{ADDR_W{1'b0}}, vertex};
	assign nbr_ext      = {{ADDR_W{1'b0}}, neighbor};
	assign vtx_in_range = 32'(vertex) < 32'(MAX_VERTICES);
	assign nbr_in_range = 32'(neighbor) < 32'(MAX_VERTICES);

	cc_ram #(
		.WIDTH (LABEL_BITS),
		.DEPTH (MAX_VERTICES)
	) u_labels (
		.clk     (clk),
		.we      (cmd.label_we && vtx_in_range),
		.waddr   (vtx_ext[ADDR_W-1:0]),
		.wdata   (label),
		.re      (cmd.edge_rd),
		.raddr_a (vtx_ext[ADDR_W-1:0]),
		.raddr_b (nbr_ext[ADDR_W-1:0]),
		.rdata_a (rd_vtx),
		.rdata_b (rd_nbr)
	);

	always_ff @(posedge clk) begin
		if (cmd.edge_rd) begin
			vtx_ok_s1 <= vtx_in_range;
			nbr_ok_s1 <= nbr_in_range;
		end
	end

	// vertices beyond the table read as label zero
	always_comb begin
		lab_vtx   = vtx_ok_s1 ? rd_vtx : '0;
		lab_nbr   = nbr_ok_s1 ? rd_nbr : '0;
		is_inside = lab_vtx == community_q;
		is_cut    = is_inside && (lab_nbr != community_q);
		den       = (inside_q < outside_q) ? inside_q : outside_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			community_q <= '0;
		end else if (cfg_we) begin
			community_q <= cfg_wdata;
		end
	end

	// saturating counters, cleared when the result is taken into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= '0;
			outside_q <= '0;
			cut_q     <= '0;
		end else if (cmd.out_load) begin
			inside_q  <= '0;
			outside_q <= '0;
			cut_q     <= '0;
		end else if (cmd.count_en) begin
			if (is_inside) begin
				if (inside_q != '1) begin
					inside_q <= inside_q + COUNT_BITS'(1);
				end
				if (is_cut && (cut_q != '1)) begin
					cut_q <= cut_q + COUNT_BITS'(1);
				end
			end else if (outside_q != '1) begin
				outside_q <= outside_q + COUNT_BITS'(1);
			end
		end
	end

	cc_divider #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (cut_q),
		.den      (den),
		.done     (div_done),
		.quotient (quotient)
	);

	assign stat.div_done = div_done;

	always_comb begin
		quo_ext = {{OUT_BITS{1'b0}}, quotient};
		quo_sat = |quo_ext[NW+OUT_BITS-1:OUT_BITS];
		in_ext  = {{VOL_BITS{1'b0}}, inside_q};
		out_ext = {{VOL_BITS{1'b0}}, outside_q};
		cut_ext = {{VOL_BITS{1'b0}}, cut_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			inside_vol_q  <= in_ext[VOL_BITS-1:0];
			outside_vol_q <= out_ext[VOL_BITS-1:0];
			cut_edges_q   <= cut_ext[VOL_BITS-1:0];
			priority if (cut_q == '0) begin
				status_q      <= CC_NO_CUT;
				conductance_q <= '1;
			end else if (den == '0) begin
				status_q      <= CC_ZERO_DEN;
				conductance_q <= '1;
			end else if (quo_sat) begin
				status_q      <= CC_SAT;
				conductance_q <= '1;
			end else begin
				status_q      <= CC_OK;
				conductance_q <= quo_ext[OUT_BITS-1:0];
			end
		end
	end

	assign conductance    = conductance_q;
	assign status         = status_q;
	assign inside_volume  = inside_vol_q;
	assign outside_volume = outside_vol_q;
	assign cut_edges      = cut_edges_q;

endmodule

// ----- hw/rtl/cc_ctrl.sv -----
module cc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output cc_pkg::cc_cmd_t   cmd,
	input  cc_pkg::cc_stat_t  stat
);

	import cc_pkg::*;

	cc_state_t state_q;
	cc_state_t state_d;
	logic      edge_s1;
	logic      last_s1;
	logic      out_valid_q;
	logic      accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			edge_s1     <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			edge_s1 <= cmd.edge_rd;
			last_s1 <= cmd.edge_rd && last;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		// a last edge in flight holds off new transactions until the result is out
		in_ready = (state_q == S_RUN) && !(edge_s1 && last_s1);
		accept   = in_valid && in_ready;
		cmd.label_we = accept && (opcode == OP_LOAD);
		cmd.edge_rd  = accept && (opcode == OP_EDGE);
		cmd.count_en = edge_s1;
		unique case (state_q)
			S_RUN: begin
				if (edge_s1 && last_s1) begin
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_RUN;
				end
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/cc_checker.sv -----
module cc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           opcode,
	input  logic                           last,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [cc_pkg::OUT_BITS-1:0]    conductance,
	input  logic [cc_pkg::STAT_BITS-1:0]   status,
	input  logic [cc_pkg::VOL_BITS-1:0]    cut_edges
);

	import cc_pkg::*;

	// a result waiting to be taken stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(conductance) && $stable(status)
			&& $stable(cut_edges))
		else $error("result payload changed while stalled");

	// any special status carries the all-ones conductance
	a_special_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != CC_OK) |-> conductance == '1)
		else $error("special status without saturated conductance");

	a_no_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == CC_NO_CUT) |-> cut_edges == '0)
		else $error("no-cut status with non-zero cut count");

	// the division after a last edge holds off the input
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_EDGE) && last |=> !in_ready)
		else $error("input taken while result is being computed");

endmodule

bind community_conductance cc_checker u_cc_checker (.*);
